// ===== rtl/kds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kds_pkg
// Shared constants, codes, types and the sine polynomial for the oscillator
// network step engine.
// ----------------------------------------------------------------------------
package kds_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int SINE_BITS_DEF = 10;

  // input transaction function codes
  localparam logic [1:0] FUNC_WEIGHT = 2'd0;
  localparam logic [1:0] FUNC_NODE   = 2'd1;
  localparam logic [1:0] FUNC_STEP   = 2'd2;
  // spare code, ignored
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_GAIN  = 2'd0;
  localparam logic [1:0] CFG_DT    = 2'd1;
  localparam logic [1:0] CFG_NODES = 2'd2;

  localparam logic [30:0] DT_RESET    = 31'd167772;
  localparam logic [6:0]  NODES_RESET = 7'd64;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 66;
  localparam int DIV_W  = 40;
  localparam int SINE_W = 26;

  // one radian as a fraction of a turn, Q32
  localparam logic signed [MUL_W-1:0] TURN_PER_RAD = 33'sd683565276;

  localparam longint SC1  = 1686629713;
  localparam longint SC3  = 693598668;
  localparam longint SC5  = 85569306;
  localparam longint SC7  = 5026995;
  localparam longint SC9  = 172272;
  localparam longint SC11 = 3864;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [DIV_W-1:0] mag;
    logic [6:0]       divisor;
  } div_req_t;

  // quarter-wave sine in Q24 for table position r (0 .. quarter)
  function automatic longint sine_quarter(input int r, input int bits);
    longint u;
    longint u2;
    longint p;
    longint s;
    u  = longint'(r) <<< (32 - bits);
    u2 = (u * u) >>> 30;
    p  = -SC11;
    p  = SC9 + ((p * u2) >>> 30);
    p  = -SC7 + ((p * u2) >>> 30);
    p  = SC5 + ((p * u2) >>> 30);
    p  = -SC3 + ((p * u2) >>> 30);
    p  = SC1 + ((p * u2) >>> 30);
    s  = (p * u) >>> 30;
    s  = (s + 32) >>> 6;
    return s;
  endfunction

endpackage

// ===== rtl/kds_sine_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kds_sine_rom
// Quarter-wave sine table with registered read; folds the angle into the
// first quadrant and restores the sign on the way out.
// ----------------------------------------------------------------------------
module kds_sine_rom #(
  parameter int SINE_TABLE_BITS = kds_pkg::SINE_BITS_DEF
) (
  input  logic                              clk,
  input  logic [31:0]                       angle,
  output logic signed [kds_pkg::SINE_W-1:0] sine
);

  localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
  localparam int AW      = SINE_TABLE_BITS - 1;

  typedef logic signed [kds_pkg::SINE_W-1:0] tab_t [QUARTER+1];

  function automatic tab_t build_tab();
    tab_t t;
    for (int r = 0; r <= QUARTER; r++) begin
      t[r] = kds_pkg::SINE_W'(kds_pkg::sine_quarter(r, SINE_TABLE_BITS));
    end
    return t;
  endfunction

  localparam tab_t TAB = build_tab();

  logic [SINE_TABLE_BITS-1:0]         k;
  logic [1:0]                         quad;
  logic [AW-1:0]                      addr;
  logic signed [kds_pkg::SINE_W-1:0]  mag_r;
  logic                               neg_r;

  always_comb begin
    k    = angle[31 -: SINE_TABLE_BITS];
    quad = k[SINE_TABLE_BITS-1 -: 2];
    if (quad[0]) begin
      addr = AW'(QUARTER) - {1'b0, k[SINE_TABLE_BITS-3:0]};
    end else begin
      addr = {1'b0, k[SINE_TABLE_BITS-3:0]};
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= TAB[addr];
    neg_r <= quad[1];
  end

  assign sine = neg_r ? -mag_r : mag_r;

endmodule

// ===== rtl/kds_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kds_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module kds_mul (
  input  logic                              clk,
  input  logic signed [kds_pkg::MUL_W-1:0]  a,
  input  logic signed [kds_pkg::MUL_W-1:0]  b,
  output logic signed [kds_pkg::PROD_W-1:0] p
);

  logic signed [kds_pkg::PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

// ===== rtl/kds_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kds_div
// Restoring divider, one quotient bit a cycle, dividing a signed value by the
// node count with truncation toward zero.
// ----------------------------------------------------------------------------
module kds_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  kds_pkg::div_req_t                req,
  output logic                             done,
  output logic signed [kds_pkg::DIV_W-1:0] quo
);

  localparam int CW = $clog2(kds_pkg::DIV_W + 1);

  logic                      busy_r;
  logic                      done_r;
  logic [CW-1:0]             cnt_r;
  logic [6:0]                rem_r;
  logic [kds_pkg::DIV_W-1:0] quo_r;
  logic [6:0]                dvs_r;
  logic                      neg_r;
  logic [7:0]                trial;
  logic                      ge;

  always_comb begin
    trial = {rem_r, quo_r[kds_pkg::DIV_W-1]};
    ge    = trial >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(kds_pkg::DIV_W);
        rem_r  <= '0;
        quo_r  <= req.mag;
        dvs_r  <= req.divisor;
        neg_r  <= req.neg;
      end else if (busy_r) begin
        // remainder stays below the divisor, so seven bits hold it
        rem_r <= ge ? 7'(trial - {1'b0, dvs_r}) : trial[6:0];
        quo_r <= {quo_r[kds_pkg::DIV_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

// ===== rtl/kuramoto_dense_step_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kuramoto_dense_step_top
// Phase oscillator network advanced by explicit Euler steps, fixed point.
// ----------------------------------------------------------------------------
// Load transactions (weight, or rate and start phase) are taken while idle.
// A step transaction holds in_stall high until all n results are taken, n
// being the node count clamped to 1 .. MAX_NODES. The coupling sum runs one
// node pair a cycle through the single shared multiplier; per node a
// bit-serial divider and four multiplier passes finish the update. New
// phases go to a second buffer and replace the old ones only as they are
// emitted.
module kuramoto_dense_step_top #(
  parameter int MAX_NODES       = kds_pkg::MAX_NODES_DEF,
  parameter int SINE_TABLE_BITS = kds_pkg::SINE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [5:0]         in_row_index,
  input  logic [5:0]         in_col_index,
  input  logic signed [31:0] in_value,
  input  logic [31:0]        in_start_phase,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         out_node_index,
  output logic [31:0]        out_phase,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int WA_W  = $clog2(MAX_NODES * MAX_NODES);
  localparam int MW    = kds_pkg::MUL_W;
  localparam int PW    = kds_pkg::PROD_W;
  localparam int DW    = kds_pkg::DIV_W;

  typedef enum logic [3:0] {
    S_IDLE, S_ROW0, S_ROW1, S_ACC, S_DRAIN, S_GAIN, S_DIVGO, S_DIV,
    S_DT, S_ALO, S_AHI, S_WR, S_EM0, S_EM1, S_EMW
  } state_t;

  state_t state_r;

  // configuration
  logic signed [31:0] gain_r;
  logic [30:0]        dt_r;
  logic [6:0]         nodes_r;

  // storage
  logic signed [31:0] weight_mem [MAX_NODES*MAX_NODES];
  logic signed [31:0] rate_mem   [MAX_NODES];
  logic [31:0]        phase_mem  [MAX_NODES];
  logic [31:0]        next_mem   [MAX_NODES];
  logic signed [31:0] weight_rd_r;
  logic signed [31:0] rate_rd_r;
  logic [31:0]        phase_rd_r;
  logic [31:0]        next_rd_r;

  // sequencer
  logic [IDX_W-1:0]   i_r;
  logic [IDX_W-1:0]   j_r;
  logic [31:0]        phi_r;
  logic signed [31:0] rate_i_r;
  logic               p1_r, p2_r, p3_r;
  logic signed [31:0] w_hold_r;
  logic signed [63:0] acc_r;
  logic signed [31:0] r_r;
  logic signed [15:0] ahi_r;
  logic [31:0]        lohi_r;

  logic               out_valid_r;
  logic [5:0]         out_idx_r;
  logic [31:0]        out_phase_r;
  logic               out_last_r;

  logic                                 in_acc;
  logic                                 row_ok, col_ok;
  logic                                 w_we, n_we;
  logic [WA_W-1:0]                      w_wa, w_ra;
  logic [IDX_W-1:0]                     ph_ra;
  logic                                 ph_we;
  logic [IDX_W-1:0]                     ph_wa;
  logic [31:0]                          ph_wd;
  logic [CNT_W-1:0]                     n_eff;
  logic [IDX_W-1:0]                     last_idx;
  logic signed [kds_pkg::SINE_W-1:0]    sine;
  logic signed [MW-1:0]                 mul_a, mul_b;
  logic signed [PW-1:0]                 prod;
  logic signed [63:0]                   acc_sh;
  logic signed [31:0]                   s_sat;
  logic signed [PW-1:0]                 gs_sh;
  logic signed [DW-1:0]                 c_val;
  kds_pkg::div_req_t                    div_req;
  logic                                 div_done;
  logic signed [DW-1:0]                 div_quo;
  logic signed [40:0]                   r_sum;
  logic signed [31:0]                   r_sat;
  logic signed [47:0]                   a_val;
  logic [31:0]                          inc;

  // configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= '0;
      dt_r    <= kds_pkg::DT_RESET;
      nodes_r <= kds_pkg::NODES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kds_pkg::CFG_GAIN:  gain_r  <= $signed(cfg_data);
        kds_pkg::CFG_DT:    dt_r    <= cfg_data[30:0];
        kds_pkg::CFG_NODES: nodes_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (nodes_r == 7'd0) begin
      n_eff = CNT_W'(1);
    end else if (nodes_r > 7'(MAX_NODES)) begin
      n_eff = CNT_W'(MAX_NODES);
    end else begin
      n_eff = CNT_W'(nodes_r);
    end
    last_idx = IDX_W'(n_eff - 1'b1);
  end

  // load decode
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign row_ok   = {1'b0, in_row_index} < 7'(MAX_NODES);
  assign col_ok   = {1'b0, in_col_index} < 7'(MAX_NODES);
  assign w_we     = in_acc && (in_func == kds_pkg::FUNC_WEIGHT) && row_ok && col_ok;
  assign n_we     = in_acc && (in_func == kds_pkg::FUNC_NODE) && row_ok;
  assign w_wa     = WA_W'(in_row_index[IDX_W-1:0] * MAX_NODES + in_col_index[IDX_W-1:0]);
  assign w_ra     = WA_W'(i_r * MAX_NODES + j_r);
  assign ph_ra    = (state_r == S_ACC) ? j_r : i_r;

  // copy the new phase over the old one as it is emitted
  always_comb begin
    ph_we = n_we || (state_r == S_EM1);
    ph_wa = n_we ? in_row_index[IDX_W-1:0] : i_r;
    ph_wd = n_we ? in_start_phase : next_rd_r;
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      weight_mem[w_wa] <= in_value;
    end
    weight_rd_r <= weight_mem[w_ra];
  end

  always_ff @(posedge clk) begin
    if (n_we) begin
      rate_mem[in_row_index[IDX_W-1:0]] <= in_value;
    end
    rate_rd_r <= rate_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (ph_we) begin
      phase_mem[ph_wa] <= ph_wd;
    end
    phase_rd_r <= phase_mem[ph_ra];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WR) begin
      next_mem[i_r] <= phi_r + inc;
    end
    next_rd_r <= next_mem[i_r];
  end

  kds_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_sine (
    .clk  (clk),
    .angle(phase_rd_r - phi_r),
    .sine (sine)
  );

  kds_mul u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (prod)
  );

  kds_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  // post-sum arithmetic
  always_comb begin
    acc_sh = acc_r >>> 24;
    if (acc_sh > 64'sd2147483647) begin
      s_sat = 32'sh7fffffff;
    end else if (acc_sh < -64'sd2147483648) begin
      s_sat = 32'sh80000000;
    end else begin
      s_sat = acc_sh[31:0];
    end
    gs_sh         = prod >>> 24;
    c_val         = gs_sh[DW-1:0];
    div_req.start = (state_r == S_DIVGO);
    div_req.neg   = c_val[DW-1];
    div_req.mag   = c_val[DW-1] ? DW'(-c_val) : DW'(c_val);
    div_req.divisor = 7'(n_eff);
    r_sum = 41'(rate_i_r) + 41'(div_quo);
    if (r_sum > 41'sd2147483647) begin
      r_sat = 32'sh7fffffff;
    end else if (r_sum < -41'sd2147483648) begin
      r_sat = 32'sh80000000;
    end else begin
      r_sat = r_sum[31:0];
    end
    a_val = prod[63:16];
    inc   = lohi_r + prod[31:0];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (p2_r) begin
      mul_a = MW'(w_hold_r);
      mul_b = MW'(sine);
    end else begin
      unique case (state_r)
        S_GAIN: begin
          mul_a = MW'(gain_r);
          mul_b = MW'(s_sat);
        end
        S_DT: begin
          mul_a = MW'(r_r);
          mul_b = $signed({2'b00, dt_r});
        end
        S_ALO: begin
          mul_a = $signed({1'b0, a_val[31:0]});
          mul_b = kds_pkg::TURN_PER_RAD;
        end
        S_AHI: begin
          mul_a = MW'(ahi_r);
          mul_b = kds_pkg::TURN_PER_RAD;
        end
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      p1_r        <= 1'b0;
      p2_r        <= 1'b0;
      p3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p1_r     <= (state_r == S_ACC);
      p2_r     <= p1_r;
      p3_r     <= p2_r;
      w_hold_r <= weight_rd_r;
      if (p3_r) begin
        acc_r <= acc_r + prod[63:0];
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_func == kds_pkg::FUNC_STEP) begin
            i_r     <= '0;
            state_r <= S_ROW0;
          end
        end
        S_ROW0: state_r <= S_ROW1;
        S_ROW1: begin
          phi_r    <= phase_rd_r;
          rate_i_r <= rate_rd_r;
          j_r      <= '0;
          acc_r    <= '0;
          state_r  <= S_ACC;
        end
        S_ACC: begin
          j_r <= j_r + 1'b1;
          if (j_r == last_idx) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!p1_r && !p2_r && !p3_r) begin
            state_r <= S_GAIN;
          end
        end
        S_GAIN:  state_r <= S_DIVGO;
        S_DIVGO: state_r <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            r_r     <= r_sat;
            state_r <= S_DT;
          end
        end
        S_DT: state_r <= S_ALO;
        S_ALO: begin
          ahi_r   <= a_val[47:32];
          state_r <= S_AHI;
        end
        S_AHI: begin
          lohi_r  <= prod[63:32];
          state_r <= S_WR;
        end
        S_WR: begin
          if (i_r == last_idx) begin
            i_r     <= '0;
            state_r <= S_EM0;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_ROW0;
          end
        end
        S_EM0: state_r <= S_EM1;
        S_EM1: begin
          out_valid_r <= 1'b1;
          out_idx_r   <= 6'(i_r);
          out_phase_r <= next_rd_r;
          out_last_r  <= (i_r == last_idx);
          state_r     <= S_EMW;
        end
        S_EMW: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_EM0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_node_index = out_idx_r;
  assign out_phase      = out_phase_r;
  assign out_last       = out_last_r;

  // no new transaction while results are pending
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while a result is pending");

  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_func == kds_pkg::FUNC_STEP) |=> in_stall)
    else $error("step transaction did not start the sequencer");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last) |=> (!out_valid && !in_stall))
    else $error("results continue after the last one");

endmodule
